// File: rtl/core/irac_pkg.sv
// Package for the IR air-conditioner frame pulse encoder.
// Holds register indexes, reset values and sequencer step constants.
// No dependencies.
package irac_pkg;

  localparam int unsigned SectionBytes = 7;
  localparam int unsigned NumRegs      = 8;
  localparam int unsigned RegIdxW      = 4;  // wide enough to see writes beyond the list
  localparam int unsigned DurW         = 16;
  localparam int unsigned CarrierHz    = 38000;

  localparam int unsigned StepW        = 6;
  localparam logic [StepW-1:0] StepHeader   = 6'd0;
  localparam logic [StepW-1:0] StepSecStart = 6'd1;
  localparam logic [StepW-1:0] StepFirstBit = 6'd2;
  localparam logic [StepW-1:0] StepClose    = StepW'(2 + 8 * SectionBytes);

  typedef enum logic [RegIdxW-1:0] {
    RegHeaderMark   = 4'd0,
    RegHeaderSpace  = 4'd1,
    RegSectionMark  = 4'd2,
    RegSectionSpace = 4'd3,
    RegBitMark      = 4'd4,
    RegOneSpace     = 4'd5,
    RegZeroSpace    = 4'd6,
    RegSectionGap   = 4'd7
  } reg_idx_e;

  typedef logic [DurW-1:0] dur_t;

  function automatic dur_t reg_reset_val(input int unsigned idx);
    dur_t v;
    v = '0;
    case (idx)
      RegHeaderMark:   v = 16'd690;
      RegHeaderSpace:  v = 16'd17844;
      RegSectionMark:  v = 16'd3086;
      RegSectionSpace: v = 16'd8864;
      RegBitMark:      v = 16'd586;
      RegOneSpace:     v = 16'd1432;
      RegZeroSpace:    v = 16'd436;
      RegSectionGap:   v = 16'd2886;
      default:         v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/ir_ac_frame_pulse_encoder.sv
// Top level of the IR air-conditioner frame pulse encoder.
// Buffers frame bytes into sections, inserts the checksum and sequences pulse pairs.
// Depends on irac_pkg.
//
// s_axis: frame bytes, one per transfer; tlast marks the final byte of a frame. Every
//   seventh byte closes a section: its checksum goes into bytes 1 and 2 and the section
//   is handed to the pulse sequencer. A frame that ends inside a section drops its
//   trailing bytes; if no section of it was sent, a lone header pair with tlast goes out.
// m_axis: one mark/space pair per transfer (header for the first section, section
//   start, eight pairs per byte LSB first, closing mark), tlast on the last frame pair.
// cfg: writes one of eight 16-bit duration registers (index 0..7, higher ignored);
//   write only while the block is idle. cfg_ready_o is always high.
// Output: the byte that closes a section loads the sequencer registers, whose first
//   step fills the output register; then one pair per cycle while m_axis is not
//   stalled, 58 or 59 pairs per section.
// Throughput: other bytes transfer every cycle, also while the sequencer runs; a byte
//   that creates sequencer work waits until the sequencer is idle.
// Reset: default durations, byte position cleared, header flag armed, sequencer and
//   output register empty.
// Stall: with m_axis_tvalid high and m_axis_tready low the output register and the sequencer step hold.
module ir_ac_frame_pulse_encoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [irac_pkg::RegIdxW-1:0]  cfg_index_i,
  input  logic [irac_pkg::DurW-1:0]     cfg_data_i,
  // byte stream in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] frame_byte
  input  logic                          s_axis_tlast,   // frame_end
  // pulse pair stream out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,   // [15:0] mark_us, [31:16] space_us
  output logic                          m_axis_tlast    // last_pulse
);
  import irac_pkg::*;

  localparam int unsigned BufBytes = SectionBytes - 1;
  localparam int unsigned PosW     = $clog2(SectionBytes);
  localparam int unsigned BitsW    = 8 * SectionBytes;
  localparam int unsigned CfgSelW  = $clog2(NumRegs);
  localparam logic [PosW-1:0] PosLast = PosW'(SectionBytes - 1);

  // ---------------------------------------------------------------- config registers
  dur_t cfg_q [NumRegs];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) cfg_q[i] <= reg_reset_val(i);
    end else if (cfg_valid_i && cfg_index_i < RegIdxW'(NumRegs)) begin
      cfg_q[cfg_index_i[CfgSelW-1:0]] <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------- section buffer
  logic [7:0]      store_q [BufBytes];
  logic [PosW-1:0] pos_q, pos_d;
  logic            first_q, first_d;

  // sequencer state
  logic             busy_q, busy_d;
  logic [StepW-1:0] step_q, step_d;
  logic [BitsW-1:0] bits_q, bits_d;
  logic             hdr_q, hdr_d;
  logic             sec_q, sec_d;
  logic             end_q, end_d;

  logic in_xfer, sec_done, hdr_only, new_job;

  assign sec_done = (pos_q == PosLast);
  assign hdr_only = !sec_done && s_axis_tlast && first_q;
  assign new_job  = sec_done || hdr_only;

  // Hold bytes that would start sequencer work while a section is still going out.
  assign s_axis_tready = !busy_q || !new_job;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // checksum over the buffered bytes and the closing byte
  logic [47:0] sum_bits;
  logic [7:0]  sum;
  logic [7:0]  csum;
  logic [7:0]  byte1, byte2;

  always_comb begin
    sum_bits = {s_axis_tdata, store_q[5], store_q[4], store_q[3],
                store_q[2][7:4], store_q[1][3:0], store_q[0]};
    sum      = 8'($countones(sum_bits));
    csum     = ~sum;
    byte1    = {csum[3:0], store_q[1][3:0]};
    byte2    = {store_q[2][7:4], csum[7:4]};
  end

  always_comb begin
    pos_d   = pos_q;
    first_d = first_q;
    if (in_xfer) begin
      if (sec_done) begin
        pos_d   = '0;
        first_d = s_axis_tlast;
      end else if (s_axis_tlast) begin
        pos_d   = '0;
        first_d = 1'b1;
      end else begin
        pos_d   = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && !sec_done) begin
      store_q[pos_q] <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      first_q <= 1'b1;
    end else begin
      pos_q   <= pos_d;
      first_q <= first_d;
    end
  end

  // ---------------------------------------------------------------- pulse sequencer
  logic advance;
  dur_t mark_d, space_d;
  logic last_d;

  assign advance = busy_q && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    busy_d  = busy_q;
    step_d  = step_q;
    bits_d  = bits_q;
    hdr_d   = hdr_q;
    sec_d   = sec_q;
    end_d   = end_q;
    mark_d  = cfg_q[CfgSelW'(RegBitMark)];
    space_d = cfg_q[CfgSelW'(RegZeroSpace)];
    last_d  = 1'b0;
    if (advance) begin
      if (step_q == StepHeader) begin
        mark_d  = cfg_q[CfgSelW'(RegHeaderMark)];
        space_d = cfg_q[CfgSelW'(RegHeaderSpace)];
        last_d  = !sec_q;
        step_d  = StepSecStart;
        busy_d  = sec_q;
      end else if (step_q == StepSecStart) begin
        mark_d  = cfg_q[CfgSelW'(RegSectionMark)];
        space_d = cfg_q[CfgSelW'(RegSectionSpace)];
        step_d  = StepFirstBit;
      end else if (step_q == StepClose) begin
        mark_d  = cfg_q[CfgSelW'(RegBitMark)];
        space_d = end_q ? '0 : cfg_q[CfgSelW'(RegSectionGap)];
        last_d  = end_q;
        busy_d  = 1'b0;
      end else begin
        mark_d  = cfg_q[CfgSelW'(RegBitMark)];
        space_d = bits_q[0] ? cfg_q[CfgSelW'(RegOneSpace)] : cfg_q[CfgSelW'(RegZeroSpace)];
        bits_d  = bits_q >> 1;
        step_d  = step_q + StepW'(1);
      end
    end else if (!busy_q && in_xfer && new_job) begin
      // load a new job: a full section, or a lone header for a short frame
      busy_d = 1'b1;
      hdr_d  = first_q;
      sec_d  = sec_done;
      end_d  = s_axis_tlast;
      step_d = first_q ? StepHeader : StepSecStart;
      bits_d = {s_axis_tdata, store_q[5], store_q[4], store_q[3], byte2, byte1, store_q[0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= StepHeader;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
    hdr_q  <= hdr_d;
    sec_q  <= sec_d;
    end_q  <= end_d;
  end

  // ---------------------------------------------------------------- output register
  logic        out_valid_q;
  logic [31:0] out_data_q;
  logic        out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {space_d, mark_d};
      out_last_q <= last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // ---------------------------------------------------------------- assertions
  // A job may only load into an idle sequencer.
  a_no_job_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (pos_q == PosLast)) |-> !busy_q)
    else $error("section closed while sequencer busy");

  // The step counter never runs past the closing pair.
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (step_q <= StepClose))
    else $error("sequencer step out of range");

  // A section job always begins with the header or the section start.
  a_job_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> (step_q == StepHeader || step_q == StepSecStart))
    else $error("sequencer started mid-section");

  // A lone header job is a header and nothing else.
  a_hdr_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !sec_q) |-> (hdr_q && step_q == StepHeader))
    else $error("header-only job in wrong step");

endmodule
